FILE: rtl/cfdv_pkg.sv
// ----------------------------------------------------------------------------
// cfdv_pkg
// Shared types and constants of the consecutive-frame detection validator:
// opcodes, result kinds, register indexes, payload structs and FSM states.
// ----------------------------------------------------------------------------
package cfdv_pkg;

  // Field widths fixed by the item format
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned MCOUNT_W   = 4;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_MIN_CONF    = 16'd0;
  localparam logic [COORD_W-1:0] RST_MIN_RADIUS  = 16'd0;
  localparam logic [COORD_W-1:0] RST_MAX_RADIUS  = 16'hFFFF;
  localparam logic [REQ_W-1:0]   RST_REQ_FRAMES  = 4'd3;
  localparam logic [DIST_W-1:0]  RST_MAX_DIST_SQ = 33'd102400;

  typedef enum logic [OP_W-1:0] {
    OP_DET     = 2'd0,
    OP_DET_EOF = 2'd1,
    OP_EOF     = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic {
    KIND_REPORT  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_CONF    = 3'd0,
    REG_MIN_RADIUS  = 3'd1,
    REG_MAX_RADIUS  = 3'd2,
    REG_REQ_FRAMES  = 3'd3,
    REG_MAX_DIST_SQ = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_ISSUE,
    ST_WAIT,
    ST_REPORT,
    ST_SUMMARY
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] min_conf;
    logic [COORD_W-1:0] radius_lo;
    logic [COORD_W-1:0] radius_hi;
    logic [REQ_W-1:0]   req_frames;
    logic [DIST_W-1:0]  max_dist_sq;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] ball_radius;
    logic [COORD_W-1:0] confidence;
  } in_item_t;

  typedef struct packed {
    kind_e               kind;
    logic                validated;
    logic [MCOUNT_W-1:0] match_count;
    logic                frame_has_ball;
    logic                frame_overflow;
    logic [CNT_W-1:0]    frame_total;
    logic [CNT_W-1:0]    detection_total;
    logic [CNT_W-1:0]    validated_total;
    logic                last;
  } out_item_t;

  // Tag of one history read travelling down the distance pipeline
  typedef struct packed {
    logic valid;
    logic epoch;
    logic last;
  } issue_t;

  typedef struct packed {
    logic valid;
    logic epoch;
    logic last;
    logic hit;
  } dist_res_t;

endpackage

FILE: rtl/cfdv_if.sv
// ----------------------------------------------------------------------------
// cfdv interfaces
// Valid/ready channels of the validator: detection input, result output and
// register write port.
// ----------------------------------------------------------------------------
interface cfdv_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfdv_pkg::OP_W-1:0]     opcode;
  logic [cfdv_pkg::COORD_W-1:0]  center_x;
  logic [cfdv_pkg::COORD_W-1:0]  center_y;
  logic [cfdv_pkg::COORD_W-1:0]  ball_radius;
  logic [cfdv_pkg::COORD_W-1:0]  confidence;

  modport source (output valid, opcode, center_x, center_y, ball_radius, confidence,
                  input ready);
  modport sink (input valid, opcode, center_x, center_y, ball_radius, confidence,
                output ready);
endinterface

interface cfdv_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic                           validated;
  logic [cfdv_pkg::MCOUNT_W-1:0]  match_count;
  logic                           frame_has_ball;
  logic                           frame_overflow;
  logic [cfdv_pkg::CNT_W-1:0]     frame_total;
  logic [cfdv_pkg::CNT_W-1:0]     detection_total;
  logic [cfdv_pkg::CNT_W-1:0]     validated_total;
  logic                           last;

  modport source (output valid, kind, validated, match_count, frame_has_ball,
                  frame_overflow, frame_total, detection_total, validated_total,
                  last, input ready);
  modport sink (input valid, kind, validated, match_count, frame_has_ball,
                frame_overflow, frame_total, detection_total, validated_total,
                last, output ready);
endinterface

interface cfdv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cfdv_pkg::CFG_IDX_W-1:0]   index;
  logic [cfdv_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/cfdv_hist_mem.sv
// ----------------------------------------------------------------------------
// cfdv_hist_mem
// History store of detection centres, {x, y} per entry. One write and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module cfdv_hist_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/cfdv_dist.sv
// ----------------------------------------------------------------------------
// cfdv_dist
// Distance pipeline: squares the centre offsets of one stored entry against
// the current detection and compares the sum with the distance limit.
// ----------------------------------------------------------------------------
module cfdv_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfdv_pkg::issue_t               issue_i,
  input  logic [cfdv_pkg::COORD_W-1:0]   px_i,
  input  logic [cfdv_pkg::COORD_W-1:0]   py_i,
  input  logic [cfdv_pkg::COORD_W-1:0]   cx_i,
  input  logic [cfdv_pkg::COORD_W-1:0]   cy_i,
  input  logic [cfdv_pkg::DIST_W-1:0]    max_dist_sq_i,
  output cfdv_pkg::dist_res_t            res_o
);

  cfdv_pkg::issue_t               tag1_q, tag2_q;
  logic [cfdv_pkg::COORD_W-1:0]   dx, dy;
  logic [cfdv_pkg::SQ_W-1:0]      sqx_d, sqy_d, sqx_q, sqy_q;
  logic [cfdv_pkg::DIST_W-1:0]    dist_sq;

  // Align the tag with the memory read, then with the squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= issue_i;
      tag2_q <= tag1_q;
    end
  end

  // Absolute offsets and their squares
  always_comb begin
    dx    = (cx_i > px_i) ? (cx_i - px_i) : (px_i - cx_i);
    dy    = (cy_i > py_i) ? (cy_i - py_i) : (py_i - cy_i);
    sqx_d = {16'd0, dx} * {16'd0, dx};
    sqy_d = {16'd0, dy} * {16'd0, dy};
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
  end

  // Sum and compare against the limit
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    res_o.valid = tag2_q.valid;
    res_o.epoch = tag2_q.epoch;
    res_o.last  = tag2_q.last;
    res_o.hit   = (dist_sq <= max_dist_sq_i);
  end

endmodule

FILE: rtl/cfdv_seq.sv
// ----------------------------------------------------------------------------
// cfdv_seq
// Sequencer of the validator: filters detections, walks the earlier frames
// newest first through the history store, keeps the frame state and the
// counters, and holds the output register.
// ----------------------------------------------------------------------------
module cfdv_seq #(
  parameter int unsigned MAX_FRAMES     = 8,
  parameter int unsigned MAX_DETECTIONS = 16,
  parameter int unsigned AW             = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfdv_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cfdv_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cfdv_pkg::out_item_t            out_item_o,
  output cfdv_pkg::issue_t               issue_o,
  output logic [AW-1:0]                  rd_addr_o,
  input  cfdv_pkg::dist_res_t            res_i,
  output logic [cfdv_pkg::COORD_W-1:0]   cx_o,
  output logic [cfdv_pkg::COORD_W-1:0]   cy_o,
  output logic                           wr_en_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic [2*cfdv_pkg::COORD_W-1:0] wr_data_o
);

  localparam int unsigned FW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_DETECTIONS + 1);
  localparam int unsigned IW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int unsigned RW = $clog2(MAX_FRAMES + 1);
  localparam logic [FW-1:0] LAST_SLOT   = FW'(MAX_FRAMES - 1);
  localparam logic [CW-1:0] DET_CAP     = CW'(MAX_DETECTIONS);
  localparam logic [AW-1:0] SLOT_STRIDE = AW'(MAX_DETECTIONS);
  localparam logic [7:0]    FRAMES_CAP  = 8'(MAX_FRAMES);

  cfdv_pkg::state_e             state_q, state_d;
  cfdv_pkg::op_e                op_q, in_op;
  logic [cfdv_pkg::COORD_W-1:0] cx_q, cy_q;
  logic [FW-1:0]                slot_q, rem_q, run_q, prev_slot;
  logic [RW-1:0]                req_q;
  logic [CW-1:0]                cnt_q, slot_cnt;
  logic [IW-1:0]                idx_q;
  logic                         epoch_q;
  logic [FW-1:0]                head_q, fill_q;
  logic [CW-1:0]                cur_cnt_q;
  logic                         any_valid_q, ovf_q;
  logic [cfdv_pkg::CNT_W-1:0]   frame_cnt_q, det_cnt_q, val_cnt_q;
  logic [CW-1:0]                frame_counts_q [MAX_FRAMES];
  logic                         out_valid_q;
  cfdv_pkg::out_item_t          out_q;

  logic       keep, cur_res, hit, miss_end, out_free, last_idx, valid_now, store_ok;
  logic       accept, start, enter_slot, issue, hit_take, do_report, do_summary;
  logic [7:0] req8, reqm1, fill8, lim8, mc8;

  // Decode the incoming item and the search bounds
  always_comb begin
    in_op = cfdv_pkg::op_e'(in_item_i.opcode);
    keep  = (in_op == cfdv_pkg::OP_DET || in_op == cfdv_pkg::OP_DET_EOF) &&
            (in_item_i.confidence >= cfg_i.min_conf) &&
            (in_item_i.ball_radius >= cfg_i.radius_lo) &&
            (in_item_i.ball_radius <= cfg_i.radius_hi);
    req8 = {4'd0, cfg_i.req_frames};
    if (req8 == 8'd0) begin
      req8 = 8'd1;
    end
    if (req8 > FRAMES_CAP) begin
      req8 = FRAMES_CAP;
    end
    reqm1 = req8 - 8'd1;
    fill8 = 8'(fill_q);
    lim8  = (fill8 < reqm1) ? fill8 : reqm1;
  end

  // Search bookkeeping
  always_comb begin
    prev_slot = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
    slot_cnt  = frame_counts_q[prev_slot];
    last_idx  = (CW'(idx_q) + CW'(1)) == cnt_q;
    cur_res   = res_i.valid && (res_i.epoch == epoch_q);
    hit       = cur_res && res_i.hit;
    miss_end  = cur_res && res_i.last && !res_i.hit;
    out_free  = !out_valid_q || out_ready_i;
    mc8       = 8'(run_q) + 8'd1;
    valid_now = mc8 >= 8'(req_q);
    store_ok  = cur_cnt_q < DET_CAP;
  end

  // Next state and strobes
  always_comb begin
    state_d    = state_q;
    accept     = 1'b0;
    start      = 1'b0;
    enter_slot = 1'b0;
    issue      = 1'b0;
    hit_take   = 1'b0;
    do_report  = 1'b0;
    do_summary = 1'b0;
    unique case (state_q)
      cfdv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          accept = 1'b1;
          if (in_op == cfdv_pkg::OP_NOP) begin
            state_d = cfdv_pkg::ST_IDLE;
          end else if (keep) begin
            start   = 1'b1;
            state_d = cfdv_pkg::ST_SLOT;
          end else if (in_op != cfdv_pkg::OP_DET) begin
            state_d = cfdv_pkg::ST_SUMMARY;
          end
        end
      end
      cfdv_pkg::ST_SLOT: begin
        if (rem_q == '0 || slot_cnt == '0) begin
          state_d = cfdv_pkg::ST_REPORT;
        end else begin
          enter_slot = 1'b1;
          state_d    = cfdv_pkg::ST_ISSUE;
        end
      end
      cfdv_pkg::ST_ISSUE: begin
        if (hit) begin
          hit_take = 1'b1;
          state_d  = cfdv_pkg::ST_SLOT;
        end else begin
          issue = 1'b1;
          if (last_idx) begin
            state_d = cfdv_pkg::ST_WAIT;
          end
        end
      end
      cfdv_pkg::ST_WAIT: begin
        if (hit) begin
          hit_take = 1'b1;
          state_d  = cfdv_pkg::ST_SLOT;
        end else if (miss_end) begin
          state_d = cfdv_pkg::ST_REPORT;
        end
      end
      cfdv_pkg::ST_REPORT: begin
        if (out_free) begin
          do_report = 1'b1;
          state_d   = (op_q == cfdv_pkg::OP_DET_EOF) ? cfdv_pkg::ST_SUMMARY
                                                     : cfdv_pkg::ST_IDLE;
        end
      end
      cfdv_pkg::ST_SUMMARY: begin
        if (out_free) begin
          do_summary = 1'b1;
          state_d    = cfdv_pkg::ST_IDLE;
        end
      end
      default: state_d = cfdv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfdv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      cx_q   <= in_item_i.center_x;
      cy_q   <= in_item_i.center_y;
      slot_q <= head_q;
      rem_q  <= lim8[FW-1:0];
      req_q  <= req8[RW-1:0];
    end
    if (start) begin
      run_q <= '0;
    end
    if (enter_slot) begin
      slot_q <= prev_slot;
      rem_q  <= rem_q - 1'b1;
      cnt_q  <= slot_cnt;
      idx_q  <= '0;
    end
    if (issue) begin
      idx_q <= idx_q + 1'b1;
    end
    if (hit_take) begin
      run_q <= run_q + 1'b1;
    end
  end

  // Frame state, counters and epoch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q        <= 1'b0;
      head_q         <= '0;
      fill_q         <= '0;
      cur_cnt_q      <= '0;
      any_valid_q    <= 1'b0;
      ovf_q          <= 1'b0;
      frame_cnt_q    <= '0;
      det_cnt_q      <= '0;
      val_cnt_q      <= '0;
      frame_counts_q <= '{default: '0};
    end else begin
      if (hit_take) begin
        epoch_q <= ~epoch_q;
      end
      if (do_report) begin
        det_cnt_q <= det_cnt_q + 1'b1;
        if (valid_now) begin
          val_cnt_q   <= val_cnt_q + 1'b1;
          any_valid_q <= 1'b1;
        end
        if (store_ok) begin
          cur_cnt_q <= cur_cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (do_summary) begin
        frame_cnt_q            <= frame_cnt_q + 1'b1;
        frame_counts_q[head_q] <= cur_cnt_q;
        head_q                 <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
        if (fill_q != LAST_SLOT) begin
          fill_q <= fill_q + 1'b1;
        end
        cur_cnt_q   <= '0;
        any_valid_q <= 1'b0;
        ovf_q       <= 1'b0;
      end
    end
  end

  // Output register: free when empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_report || do_summary) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_report) begin
      out_q.kind            <= cfdv_pkg::KIND_REPORT;
      out_q.validated       <= valid_now;
      out_q.match_count     <= mc8[cfdv_pkg::MCOUNT_W-1:0];
      out_q.frame_has_ball  <= 1'b0;
      out_q.frame_overflow  <= 1'b0;
      out_q.frame_total     <= '0;
      out_q.detection_total <= '0;
      out_q.validated_total <= '0;
      out_q.last            <= (op_q == cfdv_pkg::OP_DET);
    end else if (do_summary) begin
      out_q.kind            <= cfdv_pkg::KIND_SUMMARY;
      out_q.validated       <= 1'b0;
      out_q.match_count     <= '0;
      out_q.frame_has_ball  <= any_valid_q;
      out_q.frame_overflow  <= ovf_q;
      out_q.frame_total     <= frame_cnt_q + 1'b1;
      out_q.detection_total <= det_cnt_q;
      out_q.validated_total <= val_cnt_q;
      out_q.last            <= 1'b1;
    end
  end

  // History reads and writes
  always_comb begin
    issue_o.valid = issue;
    issue_o.epoch = epoch_q;
    issue_o.last  = last_idx;
    rd_addr_o     = AW'(slot_q) * SLOT_STRIDE + AW'(idx_q);
    wr_en_o       = do_report && store_ok;
    wr_addr_o     = AW'(head_q) * SLOT_STRIDE + AW'(cur_cnt_q);
    wr_data_o     = {cx_q, cy_q};
  end

  assign in_ready_o  = (state_q == cfdv_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cx_o        = cx_q;
  assign cy_o        = cy_q;

endmodule

FILE: rtl/consecutive_frame_detection_validator_core.sv
// ----------------------------------------------------------------------------
// consecutive_frame_detection_validator_core
// Confirms candidate detections that persist over consecutive frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one transaction per detection or end-of-frame mark. out_o gives
//   a report for each kept detection and a summary at each end of frame; the
//   last flag marks the final result of an input transaction. cfg_i writes
//   the five registers by index and is always ready; write it while idle.
// Search and throughput:
//   One input transaction is worked at a time. A kept detection walks the
//   earlier frames newest first through the single read port of the history
//   memory, one stored centre per cycle: each searched frame has a slot setup
//   step and then its reads through the read and distance pipeline, and the
//   first match ends that frame early. A detection is accepted before its
//   search and reported after the closing slot check; an end-of-frame
//   summary comes last. A dropped detection needs no search.
// Reset and stalls:
//   Reset clears the frame ring, counters and registers to their defaults;
//   the history memory needs no clearing. A stalled receiver holds the result
//   register; the next input is still taken and waits at its report or summary.
// ----------------------------------------------------------------------------
module consecutive_frame_detection_validator_core #(
  parameter int unsigned MAX_FRAMES     = 8,
  parameter int unsigned MAX_DETECTIONS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfdv_cfg_if.sink      cfg_i,
  cfdv_in_if.sink       in_i,
  cfdv_out_if.source    out_o
);

  localparam int unsigned DEPTH = MAX_FRAMES * MAX_DETECTIONS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XYW   = 2 * cfdv_pkg::COORD_W;

  cfdv_pkg::cfg_t               cfg_q;
  cfdv_pkg::in_item_t           in_item;
  cfdv_pkg::out_item_t          out_item;
  cfdv_pkg::issue_t             issue;
  cfdv_pkg::dist_res_t          res;
  logic                         out_valid;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic                         wr_en;
  logic [XYW-1:0]               wr_data, rd_data;
  logic [cfdv_pkg::COORD_W-1:0] cx, cy;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_conf    <= cfdv_pkg::RST_MIN_CONF;
      cfg_q.radius_lo   <= cfdv_pkg::RST_MIN_RADIUS;
      cfg_q.radius_hi   <= cfdv_pkg::RST_MAX_RADIUS;
      cfg_q.req_frames  <= cfdv_pkg::RST_REQ_FRAMES;
      cfg_q.max_dist_sq <= cfdv_pkg::RST_MAX_DIST_SQ;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cfdv_pkg::REG_MIN_CONF:    cfg_q.min_conf    <= cfg_i.data[cfdv_pkg::COORD_W-1:0];
        cfdv_pkg::REG_MIN_RADIUS:  cfg_q.radius_lo   <= cfg_i.data[cfdv_pkg::COORD_W-1:0];
        cfdv_pkg::REG_MAX_RADIUS:  cfg_q.radius_hi   <= cfg_i.data[cfdv_pkg::COORD_W-1:0];
        cfdv_pkg::REG_REQ_FRAMES:  cfg_q.req_frames  <= cfg_i.data[cfdv_pkg::REQ_W-1:0];
        cfdv_pkg::REG_MAX_DIST_SQ: cfg_q.max_dist_sq <= cfg_i.data[cfdv_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the input payload
  always_comb begin
    in_item.opcode      = in_i.opcode;
    in_item.center_x    = in_i.center_x;
    in_item.center_y    = in_i.center_y;
    in_item.ball_radius = in_i.ball_radius;
    in_item.confidence  = in_i.confidence;
  end

  cfdv_seq #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .AW             (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item),
    .issue_o     (issue),
    .rd_addr_o   (rd_addr),
    .res_i       (res),
    .cx_o        (cx),
    .cy_o        (cy),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  cfdv_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (XYW)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cfdv_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .px_i          (rd_data[XYW-1:cfdv_pkg::COORD_W]),
    .py_i          (rd_data[cfdv_pkg::COORD_W-1:0]),
    .cx_i          (cx),
    .cy_i          (cy),
    .max_dist_sq_i (cfg_q.max_dist_sq),
    .res_o         (res)
  );

  // Drive the result channel
  always_comb begin
    out_o.valid           = out_valid;
    out_o.kind            = out_item.kind;
    out_o.validated       = out_item.validated;
    out_o.match_count     = out_item.match_count;
    out_o.frame_has_ball  = out_item.frame_has_ball;
    out_o.frame_overflow  = out_item.frame_overflow;
    out_o.frame_total     = out_item.frame_total;
    out_o.detection_total = out_item.detection_total;
    out_o.validated_total = out_item.validated_total;
    out_o.last            = out_item.last;
  end

`ifndef SYNTHESIS
  // No new input transaction while the history search is issuing reads
  a_issue_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> !in_i.ready)
    else $error("input ready during history search");

  // Each distance result comes from a read issued earlier, through both tag registers
  a_dist_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> $past(issue.valid, 2))
    else $error("distance result without matching read");

  // Storing a detection never overlaps a history read
  a_write_vs_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !issue.valid)
    else $error("history write during search");

  // A summary always closes its input transaction
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == cfdv_pkg::KIND_SUMMARY) |-> out_o.last)
    else $error("summary without last flag");
`endif

endmodule

FILE: test/consecutive_frame_detection_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consecutive_frame_detection_validator_core_tb
// Self-checking bench for the frame track validator. A scoreboard class keeps
// its own copy of the history ring, counters and registers. It predicts every
// report and summary from the accepted detections and compares each result
// field by field. Stimulus is a short directed opening and then register
// phases of random frames that carry moving tracks, clutter, dropped
// detections and noise, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module consecutive_frame_detection_validator_core_tb;

  localparam int unsigned NUM_FRAMES    = 8;
  localparam int unsigned NUM_DETS      = 16;
  localparam int unsigned NUM_TRACKS    = 4;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned MAX_SHOWN     = 10;

  // Track confirmation scoreboard: predicted reports and summaries
  class frame_track_scoreboard;
    bit [15:0]           hist_x [NUM_FRAMES][NUM_DETS];
    bit [15:0]           hist_y [NUM_FRAMES][NUM_DETS];
    int unsigned         slot_count [NUM_FRAMES];
    int unsigned         head_slot;
    int unsigned         committed;
    int unsigned         cur_count;
    bit                  any_valid;
    bit                  overflowed;
    bit [31:0]           frames_seen;
    bit [31:0]           dets_kept;
    bit [31:0]           dets_valid;
    bit [15:0]           min_conf;
    bit [15:0]           min_rad;
    bit [15:0]           max_rad;
    bit [3:0]            req_frames;
    bit [32:0]           max_dsq;
    cfdv_pkg::out_item_t pending_results[$];
    int unsigned         mismatches;

    function new();
      foreach (slot_count[i]) slot_count[i] = 0;
      head_slot   = 0;
      committed   = 0;
      cur_count   = 0;
      any_valid   = 1'b0;
      overflowed  = 1'b0;
      frames_seen = '0;
      dets_kept   = '0;
      dets_valid  = '0;
      min_conf    = cfdv_pkg::RST_MIN_CONF;
      min_rad     = cfdv_pkg::RST_MIN_RADIUS;
      max_rad     = cfdv_pkg::RST_MAX_RADIUS;
      req_frames  = cfdv_pkg::RST_REQ_FRAMES;
      max_dsq     = cfdv_pkg::RST_MAX_DIST_SQ;
      mismatches  = 0;
    endfunction

    function void write_reg(cfdv_pkg::reg_idx_e idx, bit [32:0] data);
      case (idx)
        cfdv_pkg::REG_MIN_CONF:    min_conf   = data[15:0];
        cfdv_pkg::REG_MIN_RADIUS:  min_rad    = data[15:0];
        cfdv_pkg::REG_MAX_RADIUS:  max_rad    = data[15:0];
        cfdv_pkg::REG_REQ_FRAMES:  req_frames = data[3:0];
        cfdv_pkg::REG_MAX_DIST_SQ: max_dsq    = data;
        default: ;
      endcase
    endfunction

    // True when a stored centre of the slot lies within the allowed distance
    function bit slot_near(int unsigned slot, bit [15:0] x, bit [15:0] y);
      int unsigned n;
      bit [32:0]   dx;
      bit [32:0]   dy;
      bit          found;
      n     = (slot_count[slot] > NUM_DETS) ? NUM_DETS : slot_count[slot];
      found = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        dx = (x > hist_x[slot][i]) ? 33'(x - hist_x[slot][i]) : 33'(hist_x[slot][i] - x);
        dy = (y > hist_y[slot][i]) ? 33'(y - hist_y[slot][i]) : 33'(hist_y[slot][i] - y);
        if (dx * dx + dy * dy <= max_dsq) found = 1'b1;
      end
      return found;
    endfunction

    // Work out the results of one accepted input transaction
    function void note_input(cfdv_pkg::op_e op, bit [15:0] x, bit [15:0] y, bit [15:0] rad,
                             bit [15:0] conf);
      int unsigned         eff_req;
      int unsigned         depth;
      int unsigned         run;
      int unsigned         slot;
      bit                  broken;
      bit                  hit;
      cfdv_pkg::out_item_t res;
      if (op == cfdv_pkg::OP_NOP) return;
      if ((op == cfdv_pkg::OP_DET || op == cfdv_pkg::OP_DET_EOF) && conf >= min_conf &&
          rad >= min_rad && rad <= max_rad) begin
        eff_req = (req_frames == 0) ? 1 :
                  (req_frames > NUM_FRAMES) ? NUM_FRAMES : req_frames;
        depth   = (committed < eff_req - 1) ? committed : eff_req - 1;
        run     = 0;
        broken  = 1'b0;
        // walk earlier frames newest first, stop at the first frame with no match
        for (int unsigned k = 1; k <= depth && !broken; k++) begin
          slot = (head_slot + NUM_FRAMES - k) % NUM_FRAMES;
          if (slot_near(slot, x, y)) run++;
          else broken = 1'b1;
        end
        hit = (run + 1 >= eff_req);
        dets_kept++;
        if (hit) begin
          dets_valid++;
          any_valid = 1'b1;
        end
        if (cur_count < NUM_DETS) begin
          hist_x[head_slot][cur_count] = x;
          hist_y[head_slot][cur_count] = y;
          cur_count++;
        end else begin
          overflowed = 1'b1;
        end
        res             = '0;
        res.kind        = cfdv_pkg::KIND_REPORT;
        res.validated   = hit;
        res.match_count = 4'(run + 1);
        res.last        = (op == cfdv_pkg::OP_DET);
        pending_results.insert(pending_results.size(), res);
      end
      if (op == cfdv_pkg::OP_DET_EOF || op == cfdv_pkg::OP_EOF) begin
        frames_seen++;
        res                 = '0;
        res.kind            = cfdv_pkg::KIND_SUMMARY;
        res.frame_has_ball  = any_valid;
        res.frame_overflow  = overflowed;
        res.frame_total     = frames_seen;
        res.detection_total = dets_kept;
        res.validated_total = dets_valid;
        res.last            = 1'b1;
        pending_results.insert(pending_results.size(), res);
        // commit the frame to the ring
        slot_count[head_slot] = cur_count;
        head_slot  = (head_slot + 1) % NUM_FRAMES;
        if (committed < NUM_FRAMES - 1) committed++;
        cur_count  = 0;
        any_valid  = 1'b0;
        overflowed = 1'b0;
      end
    endfunction

    function string show(cfdv_pkg::out_item_t r);
      return {$sformatf("kind=%0d validated=%0d count=%0d ball=%0d ovf=%0d ",
                        r.kind, r.validated, r.match_count, r.frame_has_ball,
                        r.frame_overflow),
              $sformatf("frames=%0d dets=%0d vtot=%0d last=%0d",
                        r.frame_total, r.detection_total, r.validated_total, r.last)};
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(cfdv_pkg::out_item_t got);
      cfdv_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        flag({"result with nothing pending: ", show(got)});
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.kind !== want.kind || got.validated !== want.validated ||
          got.match_count !== want.match_count ||
          got.frame_has_ball !== want.frame_has_ball ||
          got.frame_overflow !== want.frame_overflow ||
          got.frame_total !== want.frame_total ||
          got.detection_total !== want.detection_total ||
          got.validated_total !== want.validated_total || got.last !== want.last)
        flag({"result mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cfdv_cfg_if cfg_if ();
  cfdv_in_if  in_if ();
  cfdv_out_if out_if ();

  consecutive_frame_detection_validator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_track_scoreboard sb = new();

  int unsigned         burst_left;
  int unsigned         cycle_count;
  int                  trk_x [NUM_TRACKS];
  int                  trk_y [NUM_TRACKS];
  bit [15:0]           ready_pattern;
  int unsigned         pattern_age;
  cfdv_pkg::out_item_t result_seen;

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL consecutive_frame_detection_validator_core");
      $finish;
    end
  end

  // Stall the result channel on a rotating pattern, reloaded now and then
  always @(negedge clk_i) begin
    out_if.ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age++;
    if (pattern_age >= 300) begin
      pattern_age = 0;
      case ($urandom_range(0, 2))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom);
        default: ready_pattern = 16'($urandom | $urandom);
      endcase
      if (ready_pattern == 16'h0) ready_pattern = 16'h1;
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      result_seen.kind            = cfdv_pkg::kind_e'(out_if.kind);
      result_seen.validated       = out_if.validated;
      result_seen.match_count     = out_if.match_count;
      result_seen.frame_has_ball  = out_if.frame_has_ball;
      result_seen.frame_overflow  = out_if.frame_overflow;
      result_seen.frame_total     = out_if.frame_total;
      result_seen.detection_total = out_if.detection_total;
      result_seen.validated_total = out_if.validated_total;
      result_seen.last            = out_if.last;
      sb.check_result(result_seen);
    end
  end

  // Send one input transaction, opening a new burst after a random gap
  task automatic send_item(cfdv_pkg::op_e op, bit [15:0] x, bit [15:0] y, bit [15:0] rad,
                           bit [15:0] conf);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.center_x    <= x;
    in_if.center_y    <= y;
    in_if.ball_radius <= rad;
    in_if.confidence  <= conf;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, x, y, rad, conf);
    burst_left--;
  endtask

  // Hold the input until every predicted result has come and the block is idle
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfdv_pkg::reg_idx_e idx, bit [32:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Idle the block, load all registers and scatter the tracks
  task automatic apply_config(bit [15:0] conf, bit [15:0] rmin, bit [15:0] rmax,
                              bit [3:0] req, bit [32:0] dsq);
    drain();
    write_reg(cfdv_pkg::REG_MIN_CONF, 33'(conf));
    write_reg(cfdv_pkg::REG_MIN_RADIUS, 33'(rmin));
    write_reg(cfdv_pkg::REG_MAX_RADIUS, 33'(rmax));
    write_reg(cfdv_pkg::REG_REQ_FRAMES, 33'(req));
    write_reg(cfdv_pkg::REG_MAX_DIST_SQ, dsq);
    foreach (trk_x[i]) begin
      trk_x[i] = $urandom_range(0, 65535);
      trk_y[i] = $urandom_range(0, 65535);
    end
  endtask

  function automatic bit [15:0] clamp16(int v);
    return (v < 0) ? 16'h0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Random frames: moving tracks with clutter, overflow, empty and noise frames
  task automatic run_frames(int unsigned n_items, int unsigned drift);
    int unsigned   sent;
    int unsigned   roll;
    int unsigned   n_tracks;
    int unsigned   n_det;
    int unsigned   t;
    bit            end_on_det;
    bit [15:0]     x;
    bit [15:0]     y;
    bit [15:0]     rad;
    bit [15:0]     conf;
    cfdv_pkg::op_e op;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // noise transaction, any opcode and any field value
        op = cfdv_pkg::op_e'($urandom_range(0, 3));
        send_item(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (op != cfdv_pkg::OP_NOP) sent++;
      end else begin
        n_tracks   = $urandom_range(1, NUM_TRACKS);
        n_det      = (roll < 15) ? NUM_DETS + $urandom_range(1, 3) :
                     (roll < 19) ? 0 : n_tracks + $urandom_range(0, 2);
        end_on_det = $urandom_range(0, 1);
        for (int unsigned j = 0; j < n_det; j++) begin
          t = j % n_tracks;
          if (j < n_tracks) begin
            // advance the track, with an occasional jump that breaks it
            if ($urandom_range(0, 19) == 0) begin
              trk_x[t] = $urandom_range(0, 65535);
              trk_y[t] = $urandom_range(0, 65535);
            end else begin
              trk_x[t] = int'(clamp16(trk_x[t] + int'($urandom_range(0, 2 * drift)) -
                                      int'(drift)));
              trk_y[t] = int'(clamp16(trk_y[t] + int'($urandom_range(0, 2 * drift)) -
                                      int'(drift)));
            end
            x = 16'(trk_x[t]);
            y = 16'(trk_y[t]);
          end else if ($urandom_range(0, 1) == 0) begin
            x = clamp16(trk_x[t] + int'($urandom_range(0, 6 * drift)) - int'(3 * drift));
            y = clamp16(trk_y[t] + int'($urandom_range(0, 6 * drift)) - int'(3 * drift));
          end else begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
          if ($urandom_range(0, 11) == 0) begin
            conf = 16'($urandom);
            rad  = 16'($urandom);
          end else begin
            conf = 16'($urandom_range(sb.min_conf, 16'hFFFF));
            rad  = 16'($urandom_range(sb.min_rad, sb.max_rad));
          end
          op = (end_on_det && j == n_det - 1) ? cfdv_pkg::OP_DET_EOF : cfdv_pkg::OP_DET;
          send_item(op, x, y, rad, conf);
          sent++;
          if ($urandom_range(0, 39) == 0)
            send_item(cfdv_pkg::OP_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        end
        if (!end_on_det || n_det == 0) begin
          send_item(cfdv_pkg::OP_EOF, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
          sent++;
        end
      end
      // let the pipeline run dry now and then
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    bit [15:0]   conf;
    bit [15:0]   rmin;
    int unsigned drift;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = cfdv_pkg::REG_MIN_CONF;
    cfg_if.data        = '0;
    in_if.valid        = 1'b0;
    in_if.opcode       = cfdv_pkg::OP_NOP;
    in_if.center_x     = '0;
    in_if.center_y     = '0;
    in_if.ball_radius  = '0;
    in_if.confidence   = '0;
    out_if.ready       = 1'b0;
    ready_pattern      = 16'hFFFF;
    pattern_age        = 0;
    burst_left         = 0;
    cycle_count        = 0;
    foreach (trk_x[i]) begin
      trk_x[i] = $urandom_range(0, 65535);
      trk_y[i] = $urandom_range(0, 65535);
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset registers: empty first frame, field extremes, short history
    send_item(cfdv_pkg::OP_EOF, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(cfdv_pkg::OP_DET, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(cfdv_pkg::OP_DET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(cfdv_pkg::OP_DET_EOF, 16'd100, 16'd100, 16'h0080, 16'h8000);
    send_item(cfdv_pkg::OP_DET, 16'h0, 16'h0, 16'h0040, 16'h1000);
    send_item(cfdv_pkg::OP_DET_EOF, 16'hFFFF, 16'hFFFF, 16'h0040, 16'h1000);
    // fourth frame validates, then two detections past the distance limit
    send_item(cfdv_pkg::OP_DET, 16'd10, 16'd10, 16'h0040, 16'h1000);
    send_item(cfdv_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(cfdv_pkg::OP_DET, 16'd330, 16'd10, 16'h0040, 16'h1000);
    send_item(cfdv_pkg::OP_DET, 16'd331, 16'd10, 16'h0040, 16'h1000);
    // fill the frame store past its capacity
    for (int unsigned i = 0; i < NUM_DETS - 2; i++)
      send_item(cfdv_pkg::OP_DET, 16'(i * 37), 16'(i * 91), 16'h0040, 16'h2000);
    send_item(cfdv_pkg::OP_EOF, 16'h0, 16'h0, 16'h0, 16'h0);
    run_frames(215, 200);

    // Filtering limits, with dropped detections on and around each edge
    apply_config(16'h4000, 16'h0100, 16'h0800, 4'd3, 33'd102400);
    send_item(cfdv_pkg::OP_DET, 16'd500, 16'd500, 16'h0400, 16'h3FFF);
    send_item(cfdv_pkg::OP_DET_EOF, 16'd500, 16'd500, 16'h0400, 16'h3FFF);
    send_item(cfdv_pkg::OP_DET, 16'd500, 16'd500, 16'h00FF, 16'hFFFF);
    send_item(cfdv_pkg::OP_DET, 16'd500, 16'd500, 16'h0801, 16'hFFFF);
    send_item(cfdv_pkg::OP_DET, 16'd500, 16'd500, 16'h0100, 16'h4000);
    send_item(cfdv_pkg::OP_DET_EOF, 16'd520, 16'd490, 16'h0800, 16'h4000);
    run_frames(275, 200);

    // Widest setting: every centre matches, eight frames needed
    apply_config(16'h0000, 16'h0000, 16'hFFFF, 4'd8, 33'h1_FFFF_FFFF);
    run_frames(300, 4000);

    // Exact position match only
    apply_config(16'hFFFF, 16'h1234, 16'h1234, 4'd4, 33'd0);
    run_frames(200, 0);

    // Empty radius window drops everything; frame count above the ring size
    apply_config(16'h0000, 16'hFFFF, 16'h0000, 4'd15, 33'd1);
    run_frames(80, 10);

    // Frame count of zero behaves as one
    apply_config(16'h0100, 16'h0000, 16'h7FFF, 4'd0, 33'd500);
    run_frames(120, 15);

    // A single frame is enough
    apply_config(16'($urandom_range(0, 16'h2000)), 16'h0000, 16'hFFFF, 4'd1,
                 33'($urandom_range(0, 200000)));
    run_frames(100, 150);

    // Random settings
    repeat (4) begin
      conf  = 16'($urandom_range(0, 16'h3000));
      rmin  = 16'($urandom_range(0, 16'h2000));
      drift = $urandom_range(0, 400);
      apply_config(conf, rmin, 16'($urandom_range(rmin, 16'hFFFF)), 4'($urandom_range(2, 8)),
                   ($urandom_range(0, 3) == 0) ? 33'(drift * drift / 2)
                                               : 33'(2 * drift * drift + $urandom_range(0, 2000)));
      run_frames(110, drift);
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("PASS consecutive_frame_detection_validator_core");
    end else begin
      $display("FAIL consecutive_frame_detection_validator_core");
    end
    $finish;
  end

endmodule
